>>> rtl/core/blob_frame_checker_defines.svh
// assertion helpers shared by the rtl
`ifndef BLOB_FRAME_CHECKER_DEFINES_SVH
`define BLOB_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blob frame checker assertion failed");

// next-cycle implication, checked outside reset
`define BFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blob frame checker assertion failed");

`endif

>>> rtl/core/bfc_pkg.sv
`timescale 1ns / 1ps

package bfc_pkg;

    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned HEADER_LEN = 14;
    localparam int unsigned KIND_COUNT = 6;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TRUNCATED   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_KIND    = 3'd4,
        ST_BAD_CRC     = 3'd5,
        ST_BAD_LENGTH  = 3'd6
    } t_status;

    typedef enum logic [0:0] {
        CFG_FRAME_MAGIC    = 1'b0,
        CFG_SCHEMA_VERSION = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [2:0] expected_kind;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [2:0]  blob_kind;
        logic [15:0] payload_length;
        logic [31:0] stored_crc;
    } t_verdict;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/bfc_frame_state.sv
`timescale 1ns / 1ps

module bfc_frame_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bfc_pkg::t_item    i_item,
    input  logic [31:0]       i_frame_magic,
    input  logic [15:0]       i_schema_version,
    output bfc_pkg::t_verdict o_verdict
);

    localparam int unsigned CW = bfc_pkg::COUNT_W;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] HDR_LEN   = CW'(bfc_pkg::HEADER_LEN);
    localparam logic [7:0]    KIND_LIM  = 8'(bfc_pkg::KIND_COUNT);

    typedef bfc_pkg::t_status t_status_l;

    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [31:0]   r_hdr_magic, n_hdr_magic;
    logic [15:0]   r_hdr_version, n_hdr_version;
    logic [7:0]    r_hdr_kind, n_hdr_kind;
    logic [15:0]   r_hdr_length, n_hdr_length;
    logic [31:0]   r_hdr_crc, n_hdr_crc;
    logic [31:0]   r_running_crc, n_running_crc;

    logic [CW-1:0] idx;
    logic [1:0]    crc_lane;
    logic [CW-1:0] need;
    t_status_l     status;

    assign idx      = r_byte_count;
    assign crc_lane = idx[1:0] - 2'd2;

    // capture the current byte and count it
    always_comb begin
        n_hdr_magic   = r_hdr_magic;
        n_hdr_version = r_hdr_version;
        n_hdr_kind    = r_hdr_kind;
        n_hdr_length  = r_hdr_length;
        n_hdr_crc     = r_hdr_crc;
        n_running_crc = r_running_crc;
        if (idx < CW'(4)) begin
            n_hdr_magic[8*idx[1:0] +: 8] = i_item.data_byte;
        end else if (idx < CW'(6)) begin
            n_hdr_version[8*idx[0] +: 8] = i_item.data_byte;
        end else if (idx == CW'(6)) begin
            n_hdr_kind = i_item.data_byte;
        end else if (idx == CW'(7)) begin
            // reserved byte
        end else if (idx < CW'(10)) begin
            n_hdr_length[8*idx[0] +: 8] = i_item.data_byte;
        end else if (idx < HDR_LEN) begin
            n_hdr_crc[8*crc_lane +: 8] = i_item.data_byte;
        end else begin
            n_running_crc = bfc_pkg::crc32_byte(r_running_crc, i_item.data_byte);
        end
        n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count : r_byte_count + CW'(1);
    end

    assign need = HDR_LEN + CW'(n_hdr_length);

    always_comb begin
        if (n_byte_count < HDR_LEN) begin
            status = bfc_pkg::ST_TRUNCATED;
        end else if (n_hdr_magic != i_frame_magic) begin
            status = bfc_pkg::ST_BAD_MAGIC;
        end else if (n_hdr_version != i_schema_version) begin
            status = bfc_pkg::ST_BAD_VERSION;
        end else if (n_hdr_kind == 8'd0 || n_hdr_kind >= KIND_LIM) begin
            status = bfc_pkg::ST_BAD_KIND;
        end else if (n_byte_count < need) begin
            status = bfc_pkg::ST_TRUNCATED;
        end else if (n_byte_count > need) begin
            status = bfc_pkg::ST_BAD_LENGTH;
        end else if (~n_running_crc != n_hdr_crc) begin
            status = bfc_pkg::ST_BAD_CRC;
        end else if (i_item.expected_kind != 3'd0
                     && {5'd0, i_item.expected_kind} != n_hdr_kind) begin
            status = bfc_pkg::ST_BAD_KIND;
        end else begin
            status = bfc_pkg::ST_OK;
        end
    end

    always_comb begin
        o_verdict.status = status;
        if (status == bfc_pkg::ST_OK) begin
            o_verdict.blob_kind      = n_hdr_kind[2:0];
            o_verdict.payload_length = n_hdr_length;
            o_verdict.stored_crc     = n_hdr_crc;
        end else begin
            o_verdict.blob_kind      = 3'd0;
            o_verdict.payload_length = 16'd0;
            o_verdict.stored_crc     = 32'd0;
        end
    end

    // the last byte re-arms for the next blob
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_byte_count  <= '0;
            r_hdr_magic   <= '0;
            r_hdr_version <= '0;
            r_hdr_kind    <= '0;
            r_hdr_length  <= '0;
            r_hdr_crc     <= '0;
            r_running_crc <= bfc_pkg::CRC_INIT;
        end else if (i_fire) begin
            r_byte_count  <= n_byte_count;
            r_hdr_magic   <= n_hdr_magic;
            r_hdr_version <= n_hdr_version;
            r_hdr_kind    <= n_hdr_kind;
            r_hdr_length  <= n_hdr_length;
            r_hdr_crc     <= n_hdr_crc;
            r_running_crc <= n_running_crc;
        end
    end

endmodule

>>> rtl/core/blob_frame_checker.sv
`timescale 1ns / 1ps

// Streaming checker for a length-prefixed blob: one byte per transaction, a 14-byte
// little-endian header (magic, version, kind, reserved, payload length, crc) and a
// crc-32 protected payload. The block takes one byte every cycle unless stalled; the
// byte goes into an input register, the next cycle captures it into the header fields
// or folds it into the byte-wide crc-32 update, and on the byte flagged last a status
// lands in the result register. The input stalls only when a last byte finds the
// result register full and stalled. Configuration writes are always ready and are to
// be made while no blob is in flight.

`include "blob_frame_checker_defines.svh"

module blob_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [2:0]  i_expected_kind,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_blob_kind,
    output logic [15:0] o_payload_length,
    output logic [31:0] o_stored_crc,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]       r_frame_magic;
    logic [15:0]       r_schema_version;
    logic              r_in_valid;
    bfc_pkg::t_item    r_in;
    logic              r_out_valid;
    bfc_pkg::t_verdict r_out;
    bfc_pkg::t_verdict verdict;

    logic in_take;
    logic out_free;
    logic proc_fire;
    logic out_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_magic    <= 32'd0;
            r_schema_version <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bfc_pkg::t_cfg_idx'(i_cfg_index))
                bfc_pkg::CFG_FRAME_MAGIC:    r_frame_magic    <= i_cfg_data;
                bfc_pkg::CFG_SCHEMA_VERSION: r_schema_version <= i_cfg_data[15:0];
            endcase
        end
    end

    // a last byte needs room in the result register, other bytes always move on
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_fire  = r_in_valid && (!r_in.last_byte || out_free);
    assign out_load   = proc_fire && r_in.last_byte;
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.data_byte     <= i_data_byte;
            r_in.last_byte     <= i_last_byte;
            r_in.expected_kind <= i_expected_kind;
        end
    end

    bfc_frame_state u_frame_state (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (proc_fire),
        .i_item           (r_in),
        .i_frame_magic    (r_frame_magic),
        .i_schema_version (r_schema_version),
        .o_verdict        (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_blob_kind      = r_out.blob_kind;
    assign o_payload_length = r_out.payload_length;
    assign o_stored_crc     = r_out.stored_crc;

    `BFC_ASSERT_NOW(a_no_stall_when_empty, !r_in_valid, !o_in_stall)
    `BFC_ASSERT_NEXT(a_result_drains, r_out_valid && !i_out_stall && !out_load, !r_out_valid)
    `BFC_ASSERT_NOW(a_fields_clear_on_error, o_out_valid && o_status != bfc_pkg::ST_OK,
        o_blob_kind == 3'd0 && o_payload_length == 16'd0 && o_stored_crc == 32'd0)
    `BFC_ASSERT_NEXT(a_last_gives_result, out_load, o_out_valid)

endmodule
